@@ src/kmdt_pkg.sv @@
// kmdt_pkg: shared types and constants of the key matrix debounce tracker
// no dependencies
package kmdt_pkg;

  localparam int unsigned DEBOUNCE_LIMIT = 65535;
  localparam logic [15:0] DEB_LIMIT_W = 16'(DEBOUNCE_LIMIT);

  localparam logic [31:0] RESET_REPEAT_THRESHOLD = 32'd16;
  localparam logic [5:0]  RESET_THROTTLE_SHIFT   = 6'd0;

  localparam logic CFG_REPEAT_THRESHOLD = 1'b0;
  localparam logic CFG_THROTTLE_SHIFT   = 1'b1;

  typedef enum logic [2:0] {
    ST_OFF     = 3'd0,
    ST_PRESS   = 3'd1,
    ST_HOLD    = 3'd2,
    ST_RELEASE = 3'd3,
    ST_INVALID = 3'd4
  } key_state_t;

  typedef struct packed {
    key_state_t  prev;
    key_state_t  cur;
    logic [15:0] active;
    logic [15:0] inactive;
    logic [31:0] last;
  } entry_t;

  typedef struct packed {
    entry_t     entry;
    logic       emit;
    key_state_t state;
  } res_t;

  localparam entry_t RESET_ENTRY = '{
    prev:     ST_OFF,
    cur:      ST_OFF,
    active:   16'd0,
    inactive: DEB_LIMIT_W,
    last:     32'd0
  };

endpackage

@@ src/kmdt_if.sv @@
// kmdt_in_if / kmdt_out_if: valid-ready channels for samples and decisions
// no dependencies
interface kmdt_in_if;
  logic       valid;
  logic       ready;
  logic [6:0] key_index;
  logic       sensed;
  logic       scan_start;
  logic       scan_reset;

  modport source (output valid, output key_index, output sensed, output scan_start,
                  output scan_reset, input ready);
  modport sink (input valid, input key_index, input sensed, input scan_start,
                input scan_reset, output ready);
endinterface

interface kmdt_out_if;
  logic       valid;
  logic       ready;
  logic [6:0] out_key;
  logic [2:0] key_state;

  modport source (output valid, output out_key, output key_state, input ready);
  modport sink (input valid, input out_key, input key_state, output ready);
endinterface

@@ src/key_matrix_debounce_tracker.sv @@
// key_matrix_debounce_tracker: top level, scan tracking, pipeline and output register
// depends on kmdt_pkg, kmdt_if, kmdt_state_mem, kmdt_resolve
// Accepts one key sample per clock cycle while the output side is ready and delivers
// any decision it yields from the output register. The rate rests on the per-key
// read-modify-write of the single state memory: the entry is read at acceptance,
// updated in the next cycle and written back as the item moves to the output register,
// with a bypass when consecutive samples hit the same key. Key state after reset comes
// from per-entry valid flops cleared at once: no clearing pass. The user must write
// configuration through cfg_we/cfg_index/cfg_data only while idle; nothing enforces it.
module key_matrix_debounce_tracker #(
  parameter int MAX_KEYS = 128
) (
  input  logic        clk,
  input  logic        rst_n,
  kmdt_in_if.sink     in_chan,
  kmdt_out_if.source  out_chan,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [31:0] cfg_data
);
  import kmdt_pkg::*;

  localparam int AW = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1;

  logic [31:0] thr_r;
  logic [5:0]  shift_r;
  logic [31:0] scan_cnt_r, scan_cnt_nxt;
  logic        scan_skip_r, scan_skip_nxt;

  logic        s1_vld_r, s1_act_r, s1_sensed_r, s1_rst_r;
  logic [6:0]  s1_key_r;
  logic [31:0] s1_scan_r;

  logic        out_vld_r;
  logic [6:0]  out_key_r;
  key_state_t  out_state_r;

  logic        accept, s1_adv, key_ok, wr_en;
  logic [7:0]  in_key_ext, s1_key_ext;
  logic [5:0]  shift_m1;
  entry_t      rd_entry;
  res_t        res;

  assign in_key_ext = {1'b0, in_chan.key_index};
  assign s1_key_ext = {1'b0, s1_key_r};
  assign key_ok     = 9'(in_key_ext) < 9'(MAX_KEYS);
  assign s1_adv     = s1_vld_r && (!out_vld_r || out_chan.ready);
  assign in_chan.ready = !s1_vld_r || s1_adv;
  assign accept     = in_chan.valid && in_chan.ready;
  assign wr_en      = s1_adv && s1_act_r;
  assign shift_m1   = shift_r - 6'd1;

  always_comb begin
    scan_cnt_nxt  = scan_cnt_r;
    scan_skip_nxt = scan_skip_r;
    if (in_chan.scan_start) begin
      scan_cnt_nxt = scan_cnt_r + 32'd1;
      priority if (shift_r == 6'd0) begin
        scan_skip_nxt = 1'b0;
      end else if (shift_r > 6'd32) begin
        scan_skip_nxt = 1'b1;
      end else begin
        scan_skip_nxt = !scan_cnt_nxt[shift_m1[4:0]];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r       <= RESET_REPEAT_THRESHOLD;
      shift_r     <= RESET_THROTTLE_SHIFT;
      scan_cnt_r  <= '0;
      scan_skip_r <= 1'b0;
      s1_vld_r    <= 1'b0;
      s1_act_r    <= 1'b0;
      out_vld_r   <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_REPEAT_THRESHOLD: thr_r   <= cfg_data;
          CFG_THROTTLE_SHIFT:   shift_r <= cfg_data[5:0];
          default: ;
        endcase
      end
      if (accept) begin
        scan_cnt_r  <= scan_cnt_nxt;
        scan_skip_r <= scan_skip_nxt;
        s1_act_r    <= !scan_skip_nxt && key_ok;
      end
      if (accept) begin
        s1_vld_r <= 1'b1;
      end else if (s1_adv) begin
        s1_vld_r <= 1'b0;
      end
      if (s1_adv) begin
        out_vld_r <= s1_act_r && res.emit;
      end else if (out_chan.ready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_key_r    <= in_chan.key_index;
      s1_sensed_r <= in_chan.sensed;
      s1_rst_r    <= in_chan.scan_reset;
      s1_scan_r   <= scan_cnt_nxt;
    end
    if (s1_adv) begin
      out_key_r   <= s1_key_r;
      out_state_r <= res.state;
    end
  end

  kmdt_state_mem #(
    .DEPTH (MAX_KEYS),
    .AW    (AW)
  ) u_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (accept),
    .rd_addr (in_key_ext[AW-1:0]),
    .wr_en   (wr_en),
    .wr_addr (s1_key_ext[AW-1:0]),
    .wr_data (res.entry),
    .rd_data (rd_entry)
  );

  kmdt_resolve u_resolve (
    .entry_in         (rd_entry),
    .sensed           (s1_sensed_r),
    .scan_reset       (s1_rst_r),
    .scan_count       (s1_scan_r),
    .repeat_threshold (thr_r),
    .res              (res)
  );

  assign out_chan.valid     = out_vld_r;
  assign out_chan.out_key   = out_key_r;
  assign out_chan.key_state = out_state_r;

endmodule

@@ src/kmdt_state_mem.sv @@
// kmdt_state_mem: per-key state memory with reset-valid bits and write bypass
// depends on kmdt_pkg
module kmdt_state_mem #(
  parameter int DEPTH = 128,
  parameter int AW    = 7
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              rd_en,
  input  logic [AW-1:0]     rd_addr,
  input  logic              wr_en,
  input  logic [AW-1:0]     wr_addr,
  input  kmdt_pkg::entry_t  wr_data,
  output kmdt_pkg::entry_t  rd_data
);
  import kmdt_pkg::*;

  entry_t           mem [DEPTH];
  logic [DEPTH-1:0] vld_r;
  entry_t           mem_q_r;
  logic             rd_vld_r;
  logic             byp_r;
  entry_t           byp_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      mem_q_r    <= mem[rd_addr];
      byp_data_r <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
      byp_r    <= 1'b0;
    end else begin
      if (wr_en) begin
        vld_r[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_vld_r <= vld_r[rd_addr];
        byp_r    <= wr_en && (wr_addr == rd_addr);
      end
    end
  end

  always_comb begin
    if (byp_r) begin
      rd_data = byp_data_r;
    end else if (rd_vld_r) begin
      rd_data = mem_q_r;
    end else begin
      rd_data = RESET_ENTRY;
    end
  end

endmodule

@@ src/kmdt_resolve.sv @@
// kmdt_resolve: counter update and state decision for one key entry
// depends on kmdt_pkg
module kmdt_resolve (
  input  kmdt_pkg::entry_t entry_in,
  input  logic             sensed,
  input  logic             scan_reset,
  input  logic [31:0]      scan_count,
  input  logic [31:0]      repeat_threshold,
  output kmdt_pkg::res_t   res
);
  import kmdt_pkg::*;

  entry_t      e;
  logic [31:0] diff;
  logic        act_wins;

  always_comb begin
    e = entry_in;
    if (scan_reset) begin
      e.prev = entry_in.cur;
      e.cur  = ST_INVALID;
    end
    if (sensed) begin
      if (e.active < DEB_LIMIT_W) begin
        e.active = e.active + 16'd1;
      end
      e.inactive = e.inactive >> 1;
    end else begin
      if (e.inactive < DEB_LIMIT_W) begin
        e.inactive = e.inactive + 16'd1;
      end
      e.active = e.active >> 1;
    end
    diff     = scan_count - e.last;
    act_wins = e.active > e.inactive;
    res.emit = 1'b0;
    if (e.cur == ST_INVALID) begin
      priority if (diff < repeat_threshold) begin
        e.cur = e.prev;
      end else begin
        res.emit = 1'b1;
        unique case (e.prev)
          ST_PRESS, ST_HOLD: begin
            if (act_wins) begin
              e.cur = ST_HOLD;
            end else begin
              e.cur  = ST_RELEASE;
              e.last = scan_count;
            end
          end
          ST_RELEASE, ST_OFF: begin
            if (act_wins) begin
              e.cur  = ST_PRESS;
              e.last = scan_count;
            end else begin
              e.cur = ST_OFF;
            end
          end
          default: e.cur = ST_INVALID;
        endcase
      end
    end
    res.entry = e;
    res.state = e.cur;
  end

endmodule

@@ sim/testbench.sv @@
// testbench for key_matrix_debounce_tracker: directed and random key samples with a
// self-checking decision predictor, random idling on both channels and register writes
// depends on kmdt_pkg, kmdt_if and the block under test
`timescale 1ns / 100ps

module testbench;
  import kmdt_pkg::*;

  localparam int NUM_KEYS = 128;
  localparam int STALL_LIMIT = 5000;

  typedef struct packed {
    logic [6:0] key_index;
    logic       sensed;
    logic       scan_start;
    logic       scan_reset;
  } sample_t;

  typedef struct packed {
    logic [6:0] key;
    key_state_t state;
  } decision_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic cfg_index;
  logic [31:0] cfg_data;

  kmdt_in_if in_if ();
  kmdt_out_if out_if ();

  key_matrix_debounce_tracker dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_if),
    .out_chan (out_if),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  // tracker copy kept alongside the block
  logic [31:0] repeat_thr;
  logic [5:0]  throttle_sh;
  logic [31:0] scans_seen;
  logic        scan_ignored;
  key_state_t  key_prev [NUM_KEYS];
  key_state_t  key_cur [NUM_KEYS];
  logic [15:0] key_active [NUM_KEYS];
  logic [15:0] key_inactive [NUM_KEYS];
  logic [31:0] key_last_change [NUM_KEYS];

  decision_t pending_decisions[$];

  int send_idle_pct;
  int recv_idle_pct;
  int hold_cycles;
  int errors;
  int samples_sent;
  int samples_tracked;
  int decisions_checked;
  int reg_writes;
  int stall_cycles;

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  function automatic bit scan_throttled();
    if (throttle_sh == 6'd0) return 1'b0;
    if (throttle_sh > 6'd32) return 1'b1;
    return scans_seen[throttle_sh - 6'd1] == 1'b0;
  endfunction

  task automatic tracker_reset();
    repeat_thr = RESET_REPEAT_THRESHOLD;
    throttle_sh = RESET_THROTTLE_SHIFT;
    scans_seen = '0;
    scan_ignored = 1'b0;
    for (int k = 0; k < NUM_KEYS; k++) begin
      key_prev[k] = ST_OFF;
      key_cur[k] = ST_OFF;
      key_active[k] = '0;
      key_inactive[k] = DEB_LIMIT_W;
      key_last_change[k] = '0;
    end
  endtask

  task automatic track_sample(input sample_t s);
    int k;
    key_state_t p;
    key_state_t res;
    logic [31:0] since;
    k = int'(s.key_index);
    if (s.scan_start) begin
      scans_seen = scans_seen + 32'd1;
      scan_ignored = scan_throttled();
    end
    if (scan_ignored || k >= NUM_KEYS) return;
    samples_tracked++;
    if (s.scan_reset) begin
      key_prev[k] = key_cur[k];
      key_cur[k] = ST_INVALID;
    end
    if (s.sensed) begin
      if (key_active[k] < DEB_LIMIT_W) key_active[k] = key_active[k] + 16'd1;
      key_inactive[k] = key_inactive[k] >> 1;
    end else begin
      if (key_inactive[k] < DEB_LIMIT_W) key_inactive[k] = key_inactive[k] + 16'd1;
      key_active[k] = key_active[k] >> 1;
    end
    if (key_cur[k] != ST_INVALID) return;
    p = key_prev[k];
    since = scans_seen - key_last_change[k];
    if (since < repeat_thr) begin
      key_cur[k] = p;
      return;
    end
    res = ST_INVALID;
    case (p)
      ST_PRESS, ST_HOLD: begin
        if (key_active[k] > key_inactive[k]) begin
          res = ST_HOLD;
        end else begin
          res = ST_RELEASE;
          key_last_change[k] = scans_seen;
        end
      end
      ST_RELEASE, ST_OFF: begin
        if (key_active[k] > key_inactive[k]) begin
          res = ST_PRESS;
          key_last_change[k] = scans_seen;
        end else begin
          res = ST_OFF;
        end
      end
      default: res = ST_INVALID;
    endcase
    key_cur[k] = res;
    pending_decisions.push_back('{key: s.key_index, state: res});
  endtask

  function automatic sample_t sample(input int k, input bit sn, input bit st, input bit rs);
    sample_t s;
    s.key_index = 7'(k);
    s.sensed = sn;
    s.scan_start = st;
    s.scan_reset = rs;
    return s;
  endfunction

  task automatic send_sample(input sample_t s);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      @(negedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.key_index <= s.key_index;
    in_if.sensed <= s.sensed;
    in_if.scan_start <= s.scan_start;
    in_if.scan_reset <= s.scan_reset;
    do @(posedge clk); while (!in_if.ready);
    samples_sent++;
    track_sample(s);
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_if.valid <= 1'b0;
    while (pending_decisions.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [31:0] data);
    wait_drained();
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_REPEAT_THRESHOLD) repeat_thr = data;
    else throttle_sh = data[5:0];
    reg_writes++;
  endtask

  // well-formed scans over a few hot keys, with some noise transactions
  task automatic run_random_scans(input int n_items);
    int start_tracked;
    int start_sent;
    int len;
    int hk;
    int key;
    bit rs;
    bit sn;
    int hot_keys [4];
    bit pressed [4];
    start_tracked = samples_tracked;
    start_sent = samples_sent;
    for (int j = 0; j < 4; j++) begin
      hot_keys[j] = $urandom_range(NUM_KEYS - 1);
      pressed[j] = 1'($urandom_range(1));
    end
    while (samples_tracked - start_tracked < n_items &&
           samples_sent - start_sent < 4 * n_items) begin
      if ($urandom_range(9) == 0) begin
        send_sample(sample($urandom_range(NUM_KEYS - 1), 1'($urandom_range(1)),
                           1'($urandom_range(1)), 1'($urandom_range(1))));
      end else begin
        len = $urandom_range(1, 6);
        rs = ($urandom_range(2) == 0);
        for (int i = 0; i < len; i++) begin
          hk = $urandom_range(3);
          if ($urandom_range(15) == 0) pressed[hk] = !pressed[hk];
          if ($urandom_range(4) == 0) begin
            key = $urandom_range(NUM_KEYS - 1);
            sn = 1'($urandom_range(1));
          end else begin
            key = hot_keys[hk];
            sn = pressed[hk] ^ ($urandom_range(9) == 0);
          end
          send_sample(sample(key, sn, i == 0, rs));
        end
        if ($urandom_range(31) == 0) hot_keys[$urandom_range(3)] = $urandom_range(NUM_KEYS - 1);
      end
    end
  endtask

  task automatic test_reset_defaults();
    send_sample(sample(0, 1'b0, 1'b0, 1'b1));
  endtask

  task automatic test_press_hold_release();
    write_reg(CFG_REPEAT_THRESHOLD, 32'd0);
    repeat (13) send_sample(sample(127, 1'b1, 1'b0, 1'b0));
    send_sample(sample(127, 1'b1, 1'b0, 1'b1));
    send_sample(sample(127, 1'b1, 1'b0, 1'b1));
    repeat (4) send_sample(sample(127, 1'b0, 1'b0, 1'b1));
  endtask

  task automatic test_throttle();
    write_reg(CFG_THROTTLE_SHIFT, 32'd1);
    send_sample(sample(0, 1'b1, 1'b1, 1'b1));
    send_sample(sample(0, 1'b1, 1'b1, 1'b1));
    send_sample(sample(0, 1'b0, 1'b0, 1'b1));
    write_reg(CFG_THROTTLE_SHIFT, 32'd40);
    send_sample(sample(64, 1'b0, 1'b1, 1'b1));
    send_sample(sample(65, 1'b1, 1'b0, 1'b1));
  endtask

  task automatic test_random_phases();
    send_idle_pct = 14;
    recv_idle_pct = 59;
    write_reg(CFG_THROTTLE_SHIFT, 32'd0);
    write_reg(CFG_REPEAT_THRESHOLD, 32'd2);
    run_random_scans(350);
    write_reg(CFG_REPEAT_THRESHOLD, 32'hFFFF_FFFF);
    run_random_scans(60);
    send_idle_pct = 59;
    recv_idle_pct = 14;
    write_reg(CFG_REPEAT_THRESHOLD, 32'd0);
    write_reg(CFG_THROTTLE_SHIFT, 32'hABCD_EF02);
    run_random_scans(180);
    write_reg(CFG_THROTTLE_SHIFT, 32'd63);
    run_random_scans(20);
    write_reg(CFG_THROTTLE_SHIFT, 32'd32);
    run_random_scans(20);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_reg(CFG_THROTTLE_SHIFT, 32'd1);
    write_reg(CFG_REPEAT_THRESHOLD, 32'd16);
    run_random_scans(180);
  endtask

  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_reg(CFG_THROTTLE_SHIFT, 32'd0);
    write_reg(CFG_REPEAT_THRESHOLD, 32'd0);
    @(posedge clk);
    hold_cycles = 300;
    for (int i = 0; i < 40; i++) begin
      send_sample(sample($urandom_range(NUM_KEYS - 1), 1'($urandom_range(1)), i == 0, 1'b1));
    end
    wait_drained();
  endtask

  initial begin
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_cycles > 0) begin
        out_if.ready <= 1'b0;
        hold_cycles--;
      end else begin
        out_if.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_if.valid && out_if.ready) begin
      if (pending_decisions.size() == 0) begin
        errors++;
        if (errors <= 10) begin
          $display("unexpected decision: key %0d state %0d", out_if.out_key, out_if.key_state);
        end
      end else begin
        decision_t want;
        want = pending_decisions.pop_front();
        decisions_checked++;
        if (out_if.out_key !== want.key || out_if.key_state !== want.state) begin
          errors++;
          if (errors <= 10) begin
            $display("decision mismatch: expected key %0d state %0d, got key %0d state %0d",
                     want.key, want.state, out_if.out_key, out_if.key_state);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("no transaction for %0d cycles, %0d decisions outstanding",
                 STALL_LIMIT, pending_decisions.size());
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  initial begin
    send_idle_pct = 14;
    recv_idle_pct = 59;
    hold_cycles = 0;
    errors = 0;
    samples_sent = 0;
    samples_tracked = 0;
    decisions_checked = 0;
    reg_writes = 0;
    stall_cycles = 0;
    rst_n <= 1'b0;
    cfg_we <= 1'b0;
    cfg_index <= CFG_REPEAT_THRESHOLD;
    cfg_data <= '0;
    in_if.valid <= 1'b0;
    in_if.key_index <= '0;
    in_if.sensed <= 1'b0;
    in_if.scan_start <= 1'b0;
    in_if.scan_reset <= 1'b0;
    tracker_reset();
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_reset_defaults();
    test_press_hold_release();
    test_throttle();
    test_random_phases();
    test_backpressure();

    wait_drained();
    repeat (8) @(posedge clk);
    $display("sent %0d samples (%0d tracked), checked %0d decisions, %0d register writes",
             samples_sent, samples_tracked, decisions_checked, reg_writes);
    $display("covered press/hold/release, throttled scans, threshold extremes, stalls");
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("%0d mismatches", errors);
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
